FILE: sv/sfp_pkg.sv
// Shared types and constants for the screen frame parser.
// No dependencies; imported by the front, back and top level modules.
`default_nettype none

package sfp_pkg;

   localparam int MAX_TEXT = 16;
   localparam int IDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
   localparam int CNT_W = $clog2(MAX_TEXT + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] END_BYTE = 8'hFF;

   localparam logic [15:0] FLAG_FRAME = 16'h1000;
   localparam logic [15:0] FLAG_FREQ = 16'h0001;
   localparam logic [15:0] FLAG_AMP = 16'h0010;
   localparam logic [15:0] FLAG_ADC = 16'h0100;
   localparam logic [15:0] FLAG_PAGE = 16'h000F;

   // Item as classified by the front end.
   typedef struct packed {
      logic       clear;
      logic       is_sync;
      logic       is_end;
      logic [7:0] data;
   } item_type;

endpackage

`default_nettype wire

FILE: sv/sfp_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on sfp_pkg.
`default_nettype none

module sfp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic             req_func,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  q_valid,
   output sfp_pkg::item_type     q_item,
   input  wire logic             q_take
);
   import sfp_pkg::*;

   item_type              q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push_ok;
   logic                  take_ok;
   item_type              new_item;

   assign req_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_item   = q_mem_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign take_ok  = q_take && q_valid;

   always_comb begin
      new_item.clear   = req_func;
      new_item.is_sync = (req_rx_byte == SYNC_BYTE);
      new_item.is_end  = (req_rx_byte == END_BYTE);
      new_item.data    = req_rx_byte;
   end

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take_ok ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !take_ok) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_ok && take_ok) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

FILE: sv/sfp_back.sv
// Back end: frame state machine, text buffer, decimal conversion and result slot.
// Depends on sfp_pkg; fed by sfp_front.
`default_nettype none

module sfp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire sfp_pkg::item_type  q_item,
   output logic                    q_take,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic                    rsp_frame_done,
   output logic                    rsp_frame_kind,
   output logic [15:0]             rsp_flag_word,
   output logic signed [31:0]      rsp_frequency,
   output logic signed [31:0]      rsp_amplitude,
   output logic signed [31:0]      rsp_adc_value
);
   import sfp_pkg::*;

   localparam logic [3:0] PH_HEADER  = 4'd0;
   localparam logic [3:0] PH_TYPE    = 4'd1;
   localparam logic [3:0] PH_SUBTYPE = 4'd2;
   localparam logic [3:0] PH_LENJUMP = 4'd3;
   localparam logic [3:0] PH_TARGET  = 4'd4;
   localparam logic [3:0] PH_TEXT    = 4'd5;
   localparam logic [3:0] PH_END1    = 4'd6;
   localparam logic [3:0] PH_END2    = 4'd7;
   localparam logic [3:0] PH_END3    = 4'd8;

   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_CONV = 1'b1;

   localparam logic [1:0] SUB_FREQ = 2'd0;
   localparam logic [1:0] SUB_AMP  = 2'd1;
   localparam logic [1:0] SUB_ADC  = 2'd2;
   localparam logic [1:0] SUB_NONE = 2'd3;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

   logic [7:0]        text_mem [MAX_TEXT];
   logic [7:0]        ch_ff;

   logic              state_ff, state_in;
   logic [3:0]        phase_ff, phase_in;
   logic              kind_ff, kind_in;
   logic [1:0]        sub_ff, sub_in;
   logic              jump_ff, jump_in;
   logic [7:0]        target_ff, target_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [15:0]       flags_ff, flags_in;
   logic [31:0]       freq_ff, freq_in;
   logic [31:0]       amp_ff, amp_in;
   logic [31:0]       adc_ff, adc_in;

   logic [CNT_W-1:0]  cv_idx_ff, cv_idx_in;
   logic              cv_digits_ff, cv_digits_in;
   logic              cv_neg_ff, cv_neg_in;
   logic [31:0]       cv_mag_ff, cv_mag_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_done_ff, out_done_in;
   logic              out_kind_ff, out_kind_in;

   logic              store_we;
   logic              out_load;
   logic              cv_finish;
   logic              is_blank, is_digit, is_sign;
   logic [3:0]        digit;
   logic [35:0]       mag_sum;
   logic [31:0]       mag_next;
   logic [31:0]       cv_value;
   logic [7:0]        b;

   assign b         = q_item.data;
   assign q_take    = q_valid && (state_ff == ST_RUN) && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   // Value registers only change when a new result enters the slot.
   assign rsp_frame_done = out_done_ff;
   assign rsp_frame_kind = out_kind_ff;
   assign rsp_flag_word  = flags_ff;
   assign rsp_frequency  = freq_ff;
   assign rsp_amplitude  = amp_ff;
   assign rsp_adc_value  = adc_ff;

   // Character classification of the buffered byte
   always_comb begin
      is_blank = (ch_ff == CH_SPACE) || ((ch_ff >= CH_TAB) && (ch_ff <= CH_CR));
      is_digit = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
      is_sign  = (ch_ff == CH_PLUS) || (ch_ff == CH_MINUS);
      digit    = 4'(ch_ff - CH_ZERO);
      mag_sum  = ({4'b0, cv_mag_ff} << 3) + ({4'b0, cv_mag_ff} << 1) + {32'b0, digit};
      mag_next = (mag_sum > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : mag_sum[31:0];
      if (cv_neg_ff) begin
         cv_value = 32'd0 - cv_mag_ff;
      end else begin
         cv_value = (cv_mag_ff > POS_LIMIT) ? POS_LIMIT : cv_mag_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      sub_in       = sub_ff;
      jump_in      = jump_ff;
      target_in    = target_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      flags_in     = flags_ff;
      freq_in      = freq_ff;
      amp_in       = amp_ff;
      adc_in       = adc_ff;
      cv_idx_in    = cv_idx_ff;
      cv_digits_in = cv_digits_ff;
      cv_neg_in    = cv_neg_ff;
      cv_mag_in    = cv_mag_ff;
      out_done_in  = out_done_ff;
      out_kind_in  = out_kind_ff;
      out_load     = 1'b0;
      store_we     = 1'b0;
      cv_finish    = 1'b0;

      unique case (state_ff)
         ST_RUN: begin
            if (q_take) begin
               out_load    = 1'b1;
               out_done_in = 1'b0;
               out_kind_in = 1'b0;
               if (q_item.clear) begin
                  flags_in = '0;
               end else begin
                  unique case (phase_ff)
                     PH_TYPE: begin
                        if (b == 8'd0) begin
                           kind_in  = 1'b0;
                           phase_in = PH_SUBTYPE;
                        end else if (b == 8'd1) begin
                           kind_in  = 1'b1;
                           phase_in = PH_LENJUMP;
                        end else begin
                           phase_in = PH_HEADER;
                        end
                     end
                     PH_SUBTYPE: begin
                        if (b == 8'd0) begin
                           sub_in = SUB_FREQ;
                        end else if (b == 8'd1) begin
                           sub_in = SUB_AMP;
                        end else if (b == 8'd2) begin
                           sub_in = SUB_ADC;
                        end else begin
                           sub_in = SUB_NONE;
                        end
                        phase_in = PH_LENJUMP;
                     end
                     PH_LENJUMP: begin
                        jump_in = (b == 8'd1);
                        if (!kind_ff) begin
                           len_in   = CNT_W'(b);
                           pos_in   = '0;
                           phase_in = ((b != 8'd0) && (b <= 8'(MAX_TEXT))) ? PH_TEXT
                                                                           : PH_HEADER;
                        end else begin
                           phase_in = PH_TARGET;
                        end
                     end
                     PH_TARGET: begin
                        target_in = b;
                        phase_in  = PH_END1;
                     end
                     PH_TEXT: begin
                        store_we = (pos_ff < CNT_W'(MAX_TEXT));
                        pos_in   = pos_ff + CNT_W'(1);
                        if (pos_in >= len_ff) begin
                           phase_in = PH_END1;
                        end
                     end
                     PH_END1: begin
                        phase_in = q_item.is_end ? PH_END2 : PH_HEADER;
                     end
                     PH_END2: begin
                        phase_in = q_item.is_end ? PH_END3 : PH_HEADER;
                     end
                     PH_END3: begin
                        phase_in = PH_HEADER;
                        if (q_item.is_end) begin
                           if (kind_ff) begin
                              out_done_in = 1'b1;
                              out_kind_in = 1'b1;
                              if (jump_ff) begin
                                 flags_in = (flags_ff & ~FLAG_PAGE) | FLAG_ADC
                                            | {12'b0, target_ff[3:0]};
                              end else begin
                                 flags_in = flags_ff | {8'b0, target_ff};
                              end
                           end else if (sub_ff == SUB_NONE) begin
                              out_done_in = 1'b1;
                              flags_in    = flags_ff | FLAG_FRAME;
                           end else begin
                              // result goes out when the conversion finishes
                              out_load     = 1'b0;
                              state_in     = ST_CONV;
                              cv_idx_in    = '0;
                              cv_digits_in = 1'b0;
                              cv_neg_in    = 1'b0;
                              cv_mag_in    = '0;
                           end
                        end
                     end
                     default: begin
                        phase_in = q_item.is_sync ? PH_TYPE : PH_HEADER;
                     end
                  endcase
               end
            end
         end
         ST_CONV: begin
            if (cv_idx_ff >= len_ff) begin
               cv_finish = 1'b1;
            end else if (!cv_digits_ff) begin
               if (is_blank) begin
                  cv_idx_in = cv_idx_ff + CNT_W'(1);
               end else if (is_sign) begin
                  cv_neg_in    = (ch_ff == CH_MINUS);
                  cv_digits_in = 1'b1;
                  cv_idx_in    = cv_idx_ff + CNT_W'(1);
               end else if (is_digit) begin
                  cv_mag_in    = {28'b0, digit};
                  cv_digits_in = 1'b1;
                  cv_idx_in    = cv_idx_ff + CNT_W'(1);
               end else begin
                  cv_finish = 1'b1;
               end
            end else begin
               if (is_digit) begin
                  cv_mag_in = mag_next;
                  cv_idx_in = cv_idx_ff + CNT_W'(1);
               end else begin
                  cv_finish = 1'b1;
               end
            end

            if (cv_finish) begin
               state_in    = ST_RUN;
               out_load    = 1'b1;
               out_done_in = 1'b1;
               out_kind_in = 1'b0;
               case (sub_ff)
                  SUB_FREQ: begin
                     freq_in  = cv_value;
                     flags_in = flags_ff | FLAG_FRAME | FLAG_FREQ;
                  end
                  SUB_AMP: begin
                     amp_in   = cv_value;
                     flags_in = flags_ff | FLAG_FRAME | FLAG_AMP;
                  end
                  SUB_ADC: begin
                     adc_in   = cv_value;
                     flags_in = flags_ff | FLAG_FRAME | FLAG_ADC;
                  end
                  default: begin
                     flags_in = flags_ff | FLAG_FRAME;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         phase_ff     <= PH_HEADER;
         kind_ff      <= 1'b0;
         sub_ff       <= SUB_FREQ;
         jump_ff      <= 1'b0;
         target_ff    <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         flags_ff     <= '0;
         freq_ff      <= '0;
         amp_ff       <= '0;
         adc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         sub_ff       <= sub_in;
         jump_ff      <= jump_in;
         target_ff    <= target_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         flags_ff     <= flags_in;
         freq_ff      <= freq_in;
         amp_ff       <= amp_in;
         adc_ff       <= adc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cv_idx_ff    <= cv_idx_in;
      cv_digits_ff <= cv_digits_in;
      cv_neg_ff    <= cv_neg_in;
      cv_mag_ff    <= cv_mag_in;
      out_done_ff  <= out_done_in;
      out_kind_ff  <= out_kind_in;
   end

   // Text buffer: written while text arrives, read one character ahead of the walk.
   always_ff @(posedge clock) begin
      if (store_we) begin
         text_mem[pos_ff[IDX_W-1:0]] <= b;
      end
      ch_ff <= text_mem[cv_idx_in[IDX_W-1:0]];
   end

endmodule

`default_nettype wire

FILE: sv/screen_frame_parser.sv
// Screen frame parser: serial byte frame decoder with flag and value registers.
// Usage:
//   Input channel (req_): push an item with req_push while req_full is low.
//     req_func = 0 carries a received byte in req_rx_byte; req_func = 1 clears
//     the flag word. A four-entry queue buffers items ahead of the parser.
//   Result channel (rsp_): every item gives exactly one result, shown while
//     rsp_empty is low and taken with rsp_pop. It carries frame_done/kind and
//     the current flag word and frequency, amplitude and ADC value registers.
//   Timing: the result slot is registered, loaded when the parser takes the item
//     from the queue. Most items are handled as they are taken; the closing
//     trailer byte of a data frame with subtype 0..2 holds the parser while the
//     character-at-a-time decimal conversion walks the text buffer (at most
//     MAX_TEXT characters).
//   Stall: while a result waits untaken, the parser holds and items collect
//     in the queue until req_full rises; nothing is lost or reordered.
//   Reset (synchronous, active high): the parser returns to header hunting,
//     the queue and result slot empty, and all flag and value registers clear.
// Depends on sfp_pkg, sfp_front and sfp_back.
`default_nettype none

module screen_frame_parser (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic          req_func,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic               rsp_frame_done,
   output logic               rsp_frame_kind,
   output logic [15:0]        rsp_flag_word,
   output logic signed [31:0] rsp_frequency,
   output logic signed [31:0] rsp_amplitude,
   output logic signed [31:0] rsp_adc_value
);
   import sfp_pkg::*;

   logic     q_valid;
   logic     q_take;
   item_type q_item;

   sfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_take      (q_take)
   );

   sfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_take         (q_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_done (rsp_frame_done),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_flag_word  (rsp_flag_word),
      .rsp_frequency  (rsp_frequency),
      .rsp_amplitude  (rsp_amplitude),
      .rsp_adc_value  (rsp_adc_value)
   );

endmodule

`default_nettype wire

FILE: sv/sfp_checker.sv
// Port-level checks for screen_frame_parser, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module sfp_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_push,
   input wire logic          req_full,
   input wire logic          rsp_empty,
   input wire logic          rsp_pop,
   input wire logic          rsp_frame_done,
   input wire logic          rsp_frame_kind,
   input wire logic [15:0]   rsp_flag_word,
   input wire logic [31:0]   rsp_frequency,
   input wire logic [31:0]   rsp_amplitude,
   input wire logic [31:0]   rsp_adc_value
);

   // Both sides come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A kind is only reported for a completed frame.
   a_kind_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_kind) |-> rsp_frame_done)
      else $error("frame kind set without frame done");

   // The input queue can only fill up through a push.
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("input full without a push");

   // A waiting result holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_flag_word)
      && $stable(rsp_frequency) && $stable(rsp_amplitude) && $stable(rsp_adc_value)
      && $stable(rsp_frame_done) && $stable(rsp_frame_kind)))
      else $error("result changed while stalled");

endmodule

bind screen_frame_parser sfp_checker u_sfp_checker (.*);

`default_nettype wire
